### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// clocked property checks, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

### design/pwi_pkg.sv
// ----------------------------------------------------------------------------
// pwi_pkg
// types, codes and pipeline step functions of the waypoint interpolator
// ----------------------------------------------------------------------------
package pwi_pkg;

  localparam int MAX_TARGETS_DEF = 16;
  localparam int MAX_STEPS_DEF   = 64;

  localparam logic [1:0] CFG_TARGET_COUNT = 2'd0;
  localparam logic [1:0] CFG_STEP_COUNT   = 2'd1;
  localparam logic [1:0] CFG_TIME_STEP    = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_TARGET = 2'd1;
  localparam logic [1:0] ST_STEP   = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam int DIV_STAGES = 31;
  localparam int FRAC_BITS  = 16;

  typedef struct packed {
    logic              cmd;
    logic [3:0]        target;
    logic [5:0]        step;
    logic signed [31:0] query_time;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic [6:0]  nst;
    logic [23:0] tse;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        query;
    logic [1:0]  status;
    logic [3:0]  target;
    logic [5:0]  step;
    logic [31:0] px;
    logic [31:0] py;
    logic        neg;
    logic [30:0] u;
    logic [23:0] rem;
    logic [6:0]  m;
    logic [15:0] frac;
  } stage_t;

  function automatic stage_t div_step(stage_t s, cfg_t c, logic [4:0] b);
    stage_t     o;
    logic [24:0] r2;
    logic [7:0]  m2;
    o  = s;
    r2 = {s.rem, s.u[b]};
    if (r2 >= {1'b0, c.tse}) begin
      r2 = r2 - {1'b0, c.tse};
      m2 = {s.m, 1'b1};
    end else begin
      m2 = {s.m, 1'b0};
    end
    if (m2 >= {1'b0, c.nst}) m2 = m2 - {1'b0, c.nst};
    o.rem = r2[23:0];
    o.m   = m2[6:0];
    return o;
  endfunction

  function automatic stage_t fix_step(stage_t s, cfg_t c);
    stage_t o;
    o = s;
    if (s.neg) begin
      o.rem = c.tse - 24'd1 - s.rem;
      o.m   = c.nst - 7'd1 - s.m;
    end
    o.frac = '0;
    return o;
  endfunction

  function automatic stage_t frac_step(stage_t s, cfg_t c);
    stage_t      o;
    logic [24:0] r2;
    logic        q;
    o  = s;
    r2 = {s.rem, 1'b0};
    q  = (r2 >= {1'b0, c.tse});
    if (q) r2 = r2 - {1'b0, c.tse};
    o.rem  = r2[23:0];
    o.frac = {s.frac[14:0], q};
    return o;
  endfunction

endpackage

### design/pwi_ram.sv
// ----------------------------------------------------------------------------
// pwi_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module pwi_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

### design/pwi_divpipe.sv
// ----------------------------------------------------------------------------
// pwi_divpipe
// pipelined floored division of time by time_step, step wrap and fraction
// ----------------------------------------------------------------------------
module pwi_divpipe import pwi_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  cfg_t   cfg,
  input  stage_t head,
  output stage_t tail
);

  localparam int NSTEP = DIV_STAGES + 1 + FRAC_BITS;

  stage_t st [NSTEP+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0] <= head;
    end
  end

  for (genvar i = 0; i < NSTEP; i++) begin : g_stage
    stage_t st_next;
    if (i < DIV_STAGES) begin : g_div
      assign st_next = div_step(st[i], cfg, 5'(DIV_STAGES - 1 - i));
    end else if (i == DIV_STAGES) begin : g_fix
      assign st_next = fix_step(st[i], cfg);
    end else begin : g_frac
      assign st_next = frac_step(st[i], cfg);
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        st[i+1].valid <= 1'b0;
      end else begin
        st[i+1] <= st_next;
      end
    end
  end

  assign tail = st[NSTEP];

endmodule

### design/periodic_waypoint_interpolator.sv
// ----------------------------------------------------------------------------
// periodic_waypoint_interpolator
// per-target waypoint table with periodic linear interpolation queries
//
//   channel   handshake              payload
//   request   start / busy           in_item_t
//   result    done strobe            out_item_t
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one transaction per cycle sustained; from acceptance to done a transaction
// passes the entry register, the 31-step quotient pipeline, one fix stage,
// 16 fraction steps, the table read, the multiply and the output register
// busy is high only during reset; done cannot be held off
// the table is not cleared, entries are valid once written
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module periodic_waypoint_interpolator import pwi_pkg::*; #(
  parameter int MAX_TARGETS = MAX_TARGETS_DEF,
  parameter int MAX_STEPS   = MAX_STEPS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  in_item_t    request,
  output logic        done,
  output out_item_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int DEPTH = MAX_TARGETS * MAX_STEPS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [4:0]  target_count;
  logic [6:0]  step_count;
  logic [23:0] time_step;
  cfg_t        cfg;

  assign cfg_ready = 1'b1;
  assign busy      = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_count <= 5'd1;
      step_count   <= 7'd1;
      time_step    <= 24'd65536;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_TARGET_COUNT: target_count <= cfg_data[4:0];
        CFG_STEP_COUNT:   step_count   <= cfg_data[6:0];
        CFG_TIME_STEP:    time_step    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign cfg.nst = (32'(step_count) > MAX_STEPS) ? 7'(MAX_STEPS) : step_count;
  assign cfg.tse = (time_step == 24'd0) ? 24'd1 : time_step;

  // entry stage
  stage_t head, tail;
  logic   tgt_ok;

  assign tgt_ok = (32'(request.target) < 32'(target_count)) &&
                  (32'(request.target) < MAX_TARGETS);

  always_comb begin
    head        = '0;
    head.valid  = start;
    head.query  = (request.cmd == CMD_QUERY);
    head.target = request.target;
    head.step   = request.step;
    head.px     = request.point_x;
    head.py     = request.point_y;
    head.neg    = request.query_time[31];
    head.u      = request.query_time[31] ? ~request.query_time[30:0]
                                         : request.query_time[30:0];
    if (!tgt_ok) begin
      head.status = ST_TARGET;
    end else if (request.cmd == CMD_WRITE) begin
      head.status = ({1'b0, request.step} >= cfg.nst) ? ST_STEP : ST_OK;
    end else begin
      head.status = (cfg.nst == 7'd0) ? ST_STEP : ST_OK;
    end
  end

  pwi_divpipe u_divpipe (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .head (head),
    .tail (tail)
  );

  // table access
  logic [7:0]    idx_inc;
  logic [6:0]    nxt_idx;
  logic [AW-1:0] addr_a, addr_b;
  logic          we;
  logic [63:0]   rdata_a, rdata_b;

  assign idx_inc = {1'b0, tail.m} + 8'd1;
  assign nxt_idx = (idx_inc >= {1'b0, cfg.nst}) ? 7'd0 : idx_inc[6:0];
  assign addr_a  = AW'(tail.target) * AW'(MAX_STEPS) +
                   (tail.query ? AW'(tail.m) : AW'(tail.step));
  assign addr_b  = AW'(tail.target) * AW'(MAX_STEPS) + AW'(nxt_idx);
  assign we      = tail.valid && !tail.query && (tail.status == ST_OK);

  pwi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (addr_a),
    .wdata ({tail.px, tail.py}),
    .raddr (addr_a),
    .rdata (rdata_a)
  );

  pwi_ram #(.WIDTH(64), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (addr_a),
    .wdata ({tail.px, tail.py}),
    .raddr (addr_b),
    .rdata (rdata_b)
  );

  // read stage
  logic        r1_valid, r1_zero;
  logic [1:0]  r1_status;
  logic [15:0] r1_frac;

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else begin
      r1_valid <= tail.valid;
    end
    r1_zero   <= !tail.query || (tail.status != ST_OK);
    r1_status <= tail.status;
    r1_frac   <= tail.frac;
  end

  // multiply stage
  logic signed [31:0] p1x, p1y, p2x, p2y;
  logic signed [32:0] dx, dy;
  logic signed [16:0] frac_s;
  logic signed [49:0] prod_x, prod_y;

  assign p1x    = rdata_a[63:32];
  assign p1y    = rdata_a[31:0];
  assign p2x    = rdata_b[63:32];
  assign p2y    = rdata_b[31:0];
  assign dx     = {p2x[31], p2x} - {p1x[31], p1x};
  assign dy     = {p2y[31], p2y} - {p1y[31], p1y};
  assign frac_s = $signed({1'b0, r1_frac});

  logic               r2_valid, r2_zero;
  logic [1:0]         r2_status;
  logic signed [49:0] r2_prod_x, r2_prod_y;
  logic signed [31:0] r2_p1x, r2_p1y;

  always_ff @(posedge clk) begin
    if (rst) begin
      r2_valid <= 1'b0;
    end else begin
      r2_valid <= r1_valid;
    end
    r2_zero   <= r1_zero;
    r2_status <= r1_status;
    r2_prod_x <= dx * frac_s;
    r2_prod_y <= dy * frac_s;
    r2_p1x    <= p1x;
    r2_p1y    <= p1y;
  end

  assign prod_x = r2_prod_x;
  assign prod_y = r2_prod_y;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r2_valid;
    end
    result.status <= r2_status;
    if (r2_zero) begin
      result.pos_x <= '0;
      result.pos_y <= '0;
    end else begin
      result.pos_x <= r2_p1x + prod_x[47:16];
      result.pos_y <= r2_p1y + prod_y[47:16];
    end
  end

  logic tail_ok_query;
  logic err_pos;

  assign tail_ok_query = tail.valid && tail.query && (tail.status == ST_OK);
  assign err_pos       = (result.status != ST_OK) &&
                         ((result.pos_x != 32'sd0) || (result.pos_y != 32'sd0));

  `ASSERT_CLK(a_latency, clk, rst, tail.valid |-> ##3 done, "result strobe missing")
  `ASSERT_CLK(a_idx_range, clk, rst, tail_ok_query |-> (tail.m < cfg.nst), "step index out of range")
  `ASSERT_NEVER(a_err_zero, clk, rst, done && err_pos, "error result carries position")

endmodule
